// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RUN(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("run-time check failed");

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("check failed");

`endif

// ===== rtl/core/s2e_pkg.sv =====
// ---------------------------------------------------------------------------
// s2e_pkg
// Shared types, constants and conversion helpers for the SJIS to EUC-JP
// stream converter.
// ---------------------------------------------------------------------------
package s2e_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 2;    // up to three bytes per item
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [0:0]        REG_HW2FW    = 1'b0;  // register index
  localparam logic [7:0]        KANA_FIRST   = 8'd161;
  localparam logic [7:0]        KANA_LAST    = 8'd223;
  localparam logic [7:0]        MARK_VOICED  = 8'd222;
  localparam logic [7:0]        MARK_SEMI    = 8'd223;
  localparam logic [CNT_W-1:0]  CNT_ONE      = 2'd1;
  localparam logic [CNT_W-1:0]  CNT_TWO      = 2'd2;
  localparam logic [CNT_W-1:0]  CNT_THREE    = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [CNT_W-1:0]  cnt;
  } s2e_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } s2e_qstat_t;

  localparam logic [15:0] KANA_ROM [0:62] = '{
    {8'd129, 8'd66},  {8'd129, 8'd117}, {8'd129, 8'd118}, {8'd129, 8'd65},
    {8'd129, 8'd69},  {8'd131, 8'd146}, {8'd131, 8'd64},  {8'd131, 8'd66},
    {8'd131, 8'd68},  {8'd131, 8'd70},  {8'd131, 8'd72},  {8'd131, 8'd131},
    {8'd131, 8'd133}, {8'd131, 8'd135}, {8'd131, 8'd98},  {8'd129, 8'd91},
    {8'd131, 8'd65},  {8'd131, 8'd67},  {8'd131, 8'd69},  {8'd131, 8'd71},
    {8'd131, 8'd73},  {8'd131, 8'd74},  {8'd131, 8'd76},  {8'd131, 8'd78},
    {8'd131, 8'd80},  {8'd131, 8'd82},  {8'd131, 8'd84},  {8'd131, 8'd86},
    {8'd131, 8'd88},  {8'd131, 8'd90},  {8'd131, 8'd92},  {8'd131, 8'd94},
    {8'd131, 8'd96},  {8'd131, 8'd99},  {8'd131, 8'd101}, {8'd131, 8'd103},
    {8'd131, 8'd105}, {8'd131, 8'd106}, {8'd131, 8'd107}, {8'd131, 8'd108},
    {8'd131, 8'd109}, {8'd131, 8'd110}, {8'd131, 8'd113}, {8'd131, 8'd116},
    {8'd131, 8'd119}, {8'd131, 8'd122}, {8'd131, 8'd125}, {8'd131, 8'd126},
    {8'd131, 8'd128}, {8'd131, 8'd129}, {8'd131, 8'd130}, {8'd131, 8'd132},
    {8'd131, 8'd134}, {8'd131, 8'd136}, {8'd131, 8'd137}, {8'd131, 8'd138},
    {8'd131, 8'd139}, {8'd131, 8'd140}, {8'd131, 8'd141}, {8'd131, 8'd143},
    {8'd131, 8'd147}, {8'd129, 8'd74},  {8'd129, 8'd75}
  };

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'd129 && b <= 8'd159) || (b >= 8'd224 && b <= 8'd239);
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return (b >= 8'd64) && (b <= 8'd252);
  endfunction

  function automatic logic is_kana(input logic [7:0] b);
    return (b >= KANA_FIRST) && (b <= KANA_LAST);
  endfunction

  function automatic logic takes_voiced(input logic [7:0] k);
    return (k >= 8'd182 && k <= 8'd196) || (k >= 8'd202 && k <= 8'd206) ||
           (k == 8'd179);
  endfunction

  function automatic logic takes_semi(input logic [7:0] k);
    return (k >= 8'd202) && (k <= 8'd206);
  endfunction

  // SJIS pair to EUC-JP pair, mod 256
  function automatic logic [15:0] sjis_pair(input logic [7:0] c1,
                                            input logic [7:0] c2);
    logic       adj;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] e1;
    logic [7:0] e2;
    adj  = (c2 < 8'd159);
    row  = (c1 < 8'd160) ? 8'd112 : 8'd176;
    col  = adj ? ((c2 > 8'd127) ? 8'd32 : 8'd31) : 8'd126;
    e1   = ((c1 - row) << 1) - {7'd0, adj} + 8'd128;
    e2   = c2 - col + 8'd128;
    return {e1, e2};
  endfunction

  // Returns {merged, c1, c2} for a held kana and a following byte
  function automatic logic [16:0] kana_convert(input logic [7:0] kv,
                                               input logic [7:0] mark);
    logic [7:0]  idx;
    logic [15:0] ent;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic        merged;
    idx = kv - KANA_FIRST;
    if (idx > 8'd62) begin
      idx = 8'd62;
    end
    ent    = KANA_ROM[idx[5:0]];
    c1     = ent[15:8];
    c2     = ent[7:0];
    merged = 1'b0;
    if (mark == MARK_VOICED && takes_voiced(kv)) begin
      if ((c2 >= 8'd74 && c2 <= 8'd103) || (c2 >= 8'd110 && c2 <= 8'd122)) begin
        c2 = c2 + 8'd1;
      end else if (c1 == 8'd131 && c2 == 8'd69) begin
        c2 = 8'd148;
      end
      merged = 1'b1;
    end else if (mark == MARK_SEMI && takes_semi(kv) &&
                 c2 >= 8'd110 && c2 <= 8'd122) begin
      c2     = c2 + 8'd2;
      merged = 1'b1;
    end
    return {merged, c1, c2};
  endfunction

endpackage

// ===== rtl/core/s2e_front.sv =====
// ---------------------------------------------------------------------------
// s2e_front
// Accepts SJIS bytes, tracks held lead / kana bytes and builds one queue
// entry of up to three EUC-JP bytes per item.
// ---------------------------------------------------------------------------
module s2e_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [s2e_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_text_end,
  input  logic                       hw2fw,
  input  s2e_pkg::s2e_qstat_t        qstat,
  output logic                       full,
  output logic                       q_push,
  output s2e_pkg::s2e_entry_t        q_data
);
  import s2e_pkg::*;

  logic              lead_held_r, lead_held_nxt;
  logic [BYTE_W-1:0] lead_value_r, lead_value_nxt;
  logic              kana_held_r, kana_held_nxt;
  logic [BYTE_W-1:0] kana_value_r, kana_value_nxt;

  logic        accept;
  logic        text_done;
  logic [16:0] kconv;
  logic [15:0] kpair;
  logic [15:0] lpair;
  s2e_entry_t  ent;

  assign full      = qstat.full;
  assign accept    = push && !qstat.full;
  assign text_done = in_text_end || (in_byte == '0);

  // a text end never merges into the kana
  assign kconv = kana_convert(kana_value_r, text_done ? '0 : in_byte);
  assign kpair = sjis_pair(kconv[15:8], kconv[7:0]);
  assign lpair = sjis_pair(lead_value_r, in_byte);

  always_comb begin
    lead_held_nxt  = lead_held_r;
    lead_value_nxt = lead_value_r;
    kana_held_nxt  = kana_held_r;
    kana_value_nxt = kana_value_r;
    ent            = '0;
    if (accept) begin
      if (text_done) begin
        if (kana_held_r) begin
          ent.b0  = kpair[15:8];
          ent.b1  = kpair[7:0];
          ent.cnt = CNT_THREE;
        end else begin
          ent.cnt = CNT_ONE;
        end
        lead_held_nxt  = 1'b0;
        lead_value_nxt = '0;
        kana_held_nxt  = 1'b0;
        kana_value_nxt = '0;
      end else if (lead_held_r) begin
        if (is_trail(in_byte)) begin
          ent.b0 = lpair[15:8];
          ent.b1 = lpair[7:0];
        end else begin
          ent.b0 = lead_value_r;
          ent.b1 = in_byte;
        end
        ent.cnt        = CNT_TWO;
        lead_held_nxt  = 1'b0;
        lead_value_nxt = '0;
      end else begin
        if (kana_held_r) begin
          ent.b0         = kpair[15:8];
          ent.b1         = kpair[7:0];
          ent.cnt        = CNT_TWO;
          kana_held_nxt  = 1'b0;
          kana_value_nxt = '0;
        end
        if (!(kana_held_r && kconv[16])) begin
          if (is_lead(in_byte)) begin
            lead_held_nxt  = 1'b1;
            lead_value_nxt = in_byte;
          end else if (is_kana(in_byte) && hw2fw) begin
            kana_held_nxt  = 1'b1;
            kana_value_nxt = in_byte;
          end else if (kana_held_r) begin
            ent.b2  = in_byte;
            ent.cnt = CNT_THREE;
          end else begin
            ent.b0  = in_byte;
            ent.cnt = CNT_ONE;
          end
        end
      end
    end
  end

  assign q_push = accept && (ent.cnt != '0);
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_held_r  <= 1'b0;
      lead_value_r <= '0;
      kana_held_r  <= 1'b0;
      kana_value_r <= '0;
    end else begin
      lead_held_r  <= lead_held_nxt;
      lead_value_r <= lead_value_nxt;
      kana_held_r  <= kana_held_nxt;
      kana_value_r <= kana_value_nxt;
    end
  end

endmodule

// ===== rtl/core/s2e_queue.sv =====
// ---------------------------------------------------------------------------
// s2e_queue
// Short FIFO of converted entries between front and back.
// ---------------------------------------------------------------------------
module s2e_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  s2e_pkg::s2e_entry_t  wr_data,
  input  logic                 rd_en,
  output s2e_pkg::s2e_entry_t  rd_data,
  output s2e_pkg::s2e_qstat_t  qstat
);
  import s2e_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

  s2e_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_wr;
  logic              do_rd;

  assign qstat.full  = (count_r == CNT_FULL);
  assign qstat.empty = (count_r == '0);
  assign do_wr       = wr_en && !qstat.full;
  assign do_rd       = rd_en && !qstat.empty;
  assign rd_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/s2e_back.sv =====
// ---------------------------------------------------------------------------
// s2e_back
// Walks the head entry one byte a cycle into the output register while it is free or popped.
// ---------------------------------------------------------------------------
module s2e_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  s2e_pkg::s2e_entry_t        head,
  input  s2e_pkg::s2e_qstat_t        qstat,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [s2e_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import s2e_pkg::*;

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              load;
  logic              at_end;
  logic [BYTE_W-1:0] sel;

  assign load   = !qstat.empty && (!valid_r || pop);
  assign at_end = (idx_r == head.cnt - CNT_ONE);
  assign q_pop  = load && at_end;

  always_comb begin
    case (idx_r)
      2'd0:    sel = head.b0;
      2'd1:    sel = head.b1;
      default: sel = head.b2;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = sel;
      last_nxt  = at_end;
      idx_nxt   = at_end ? '0 : idx_r + 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
      byte_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
      byte_r  <= byte_nxt;
      last_r  <= last_nxt;
    end
  end

  assign empty    = !valid_r;
  assign out_byte = byte_r;
  assign out_last = last_r;

endmodule

// ===== rtl/core/sjis_to_eucjp_stream_top.sv =====
// ---------------------------------------------------------------------------
// sjis_to_eucjp_stream_top
// Shift-JIS byte stream in, EUC-JP byte stream out, with optional
// half-width to full-width katakana conversion.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  input    | push / full            | in_byte, in_text_end
//  result   | pop / empty            | out_byte, out_last
//  config   | psel, penable, pready  | paddr, pwdata, prdata (reg 0 at 0x0)
//
//  The front takes one item per cycle while the entry queue has room.
//  The back sends one result beat per cycle while its output register is free or
//  being popped, walking each item's bytes (0 to 3) out in order; that walk sets the rate.
//  An accepted item passes through the entry queue, then the output register, to the ports.
//  Synchronous active-low reset; no clearing pass. Either side may stall.
// ---------------------------------------------------------------------------
module sjis_to_eucjp_stream_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [s2e_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           in_text_end,
  output logic                           empty,
  input  logic                           pop,
  output logic [s2e_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [s2e_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [s2e_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [s2e_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import s2e_pkg::*;

  logic       hw2fw_r, hw2fw_nxt;
  logic       cfg_wr;
  logic       q_push;
  logic       q_pop;
  s2e_entry_t q_wdata;
  s2e_entry_t q_head;
  s2e_qstat_t qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HW2FW) ? {{(CFG_DATA_W-1){1'b0}}, hw2fw_r} : '0;

  always_comb begin
    hw2fw_nxt = hw2fw_r;
    if (cfg_wr && paddr[2] == REG_HW2FW) begin
      hw2fw_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw2fw_r <= 1'b1;
    end else begin
      hw2fw_r <= hw2fw_nxt;
    end
  end

  s2e_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_byte     (in_byte),
    .in_text_end (in_text_end),
    .hw2fw       (hw2fw_r),
    .qstat       (qstat),
    .full        (full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  s2e_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .qstat   (qstat)
  );

  s2e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .qstat    (qstat),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// ===== rtl/core/s2e_checker.sv =====
// ---------------------------------------------------------------------------
// s2e_checker
// Port-level checks for the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module s2e_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [s2e_pkg::BYTE_W-1:0]     out_byte,
  input logic                           out_last
);
  import s2e_pkg::*;

  // coming out of reset both sides are idle
  `ASSERT_ANY(a_rst_empty, clk, !rst_n |=> empty)
  `ASSERT_ANY(a_rst_room, clk, !rst_n |=> !full)
  // a waiting beat holds until taken
  `ASSERT_RUN(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
  // a zero byte is only ever the terminator, which closes its item
  `ASSERT_RUN(a_term_last, clk, rst_n, (!empty && out_byte == '0) |-> out_last)

endmodule

bind sjis_to_eucjp_stream_top s2e_checker u_s2e_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .out_last (out_last)
);
